/* design/rbs_pkg.sv */
// ----------------------------------------------------------------------------
// rbs_pkg: shared types, constants and functions of the retry backoff scheduler
// Slot states, operation codes, channel words, controller states and the
// retry / backoff rules used by the datapath.
// ----------------------------------------------------------------------------
package rbs_pkg;

    // table size default, range 2..16 (the slot field is SLOT_W bits)
    localparam int SLOTS_DEF = 16;

    // field widths
    localparam int FUNC_W    = 2;
    localparam int SLOT_W    = 4;
    localparam int TIME_W    = 48;
    localparam int CODE_W    = 10;
    localparam int STATUS_W  = 2;
    localparam int STATE_W   = 3;
    localparam int DELAY_W   = 24;
    localparam int AGE_W     = 40;
    localparam int COUNT_W   = 8;
    localparam int SWEPT_W   = 5;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = AGE_W;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE   = 1'd1;
    localparam logic [DELAY_W-1:0]   MAX_DELAY_RST = 24'd300000;
    localparam logic [AGE_W-1:0]     MAX_AGE_RST   = 40'd86400000;

    // backoff and retry rules
    localparam logic [DELAY_W-1:0] BASE_DELAY_MS = 24'd1000;
    localparam logic [COUNT_W-1:0] MAX_SHIFT     = 8'd10;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = 8'd255;
    localparam logic [CODE_W-1:0]  CODE_NETWORK  = 10'd0;
    localparam logic [CODE_W-1:0]  CODE_THROTTLE = 10'd429;
    localparam logic [CODE_W-1:0]  CODE_5XX_LO   = 10'd500;
    localparam logic [CODE_W-1:0]  CODE_5XX_HI   = 10'd599;
    localparam logic [COUNT_W-1:0] LIMIT_5XX     = 8'd5;
    localparam logic [COUNT_W-1:0] LIMIT_NETWORK = 8'd8;
    localparam logic [SWEPT_W-1:0] SWEPT_MAX     = 5'd31;

    typedef enum logic [FUNC_W-1:0] {
        F_ENQUEUE = 2'd0,
        F_REPORT  = 2'd1,
        F_PICK    = 2'd2,
        F_SWEEP   = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE   = 2'd0,
        ST_CHOSEN = 2'd1,
        ST_NONE   = 2'd2
    } t_status;

    typedef enum logic [STATE_W-1:0] {
        SLOT_EMPTY    = 3'd0,
        SLOT_PENDING  = 3'd1,
        SLOT_RETRYING = 3'd2,
        SLOT_SENT     = 3'd3,
        SLOT_FAILED   = 3'd4
    } t_slot_st;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] now_ms;
        logic              success;
        logic [CODE_W-1:0] error_code;
    } t_in_word;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_out;
        logic [STATE_W-1:0]  slot_state_out;
        logic                will_retry;
        logic [DELAY_W-1:0]  backoff_ms;
        logic [COUNT_W-1:0]  retries;
        logic [SWEPT_W-1:0]  swept_count;
    } t_out_word;

    // per-slot attempt record
    typedef struct packed {
        logic [COUNT_W-1:0] cnt;
        logic [CODE_W-1:0]  err;
        logic [TIME_W-1:0]  last;
    } t_meta;

    typedef enum logic [2:0] {
        C_IDLE,
        C_ENQ,
        C_RPT_RD,
        C_RPT_WR,
        C_SCAN,
        C_PUSH
    } t_ctrl_state;

    typedef struct packed {
        logic capture;
        logic enq;
        logic rpt;
        logic scan;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_stat;

    function automatic logic [DELAY_W-1:0] backoff_calc(
        input logic [COUNT_W-1:0] cnt,
        input logic [DELAY_W-1:0] cap
    );
        logic [3:0]         sh;
        logic [DELAY_W-1:0] d;
        sh = (cnt < MAX_SHIFT) ? cnt[3:0] : MAX_SHIFT[3:0];
        d  = BASE_DELAY_MS << sh;
        return (d > cap) ? cap : d;
    endfunction

    function automatic logic retry_ok(
        input logic [COUNT_W-1:0] cnt,
        input logic [CODE_W-1:0]  code
    );
        logic ok;
        if (code == CODE_THROTTLE) begin
            ok = 1'b1;
        end else if (code inside {[CODE_5XX_LO:CODE_5XX_HI]}) begin
            ok = (cnt < LIMIT_5XX);
        end else if (code == CODE_NETWORK) begin
            ok = (cnt < LIMIT_NETWORK);
        end else begin
            ok = 1'b0;
        end
        return ok;
    endfunction

endpackage

/* design/rbs_in_if.sv */
// ----------------------------------------------------------------------------
// rbs_in_if: request channel of the retry backoff scheduler
// valid / ready handshake carrying one request word.
// ----------------------------------------------------------------------------
interface rbs_in_if;
    import rbs_pkg::*;

    logic     valid;
    logic     ready;
    t_in_word payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* design/rbs_out_if.sv */
// ----------------------------------------------------------------------------
// rbs_out_if: result channel of the retry backoff scheduler
// valid / ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface rbs_out_if;
    import rbs_pkg::*;

    logic      valid;
    logic      ready;
    t_out_word payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* design/rbs_ctrl.sv */
// ----------------------------------------------------------------------------
// rbs_ctrl: sequencer of the retry backoff scheduler
// Takes one request at a time and steps the datapath through it.
// ----------------------------------------------------------------------------
module rbs_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [rbs_pkg::FUNC_W-1:0]    i_func,
    input  rbs_pkg::t_stat                i_stat,
    output logic                          o_in_ready,
    output rbs_pkg::t_cmd                 o_cmd
);
    import rbs_pkg::*;

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            C_IDLE: begin
                if (i_in_valid) begin
                    case (t_func'(i_func))
                        F_ENQUEUE: n_state = C_ENQ;
                        F_REPORT:  n_state = C_RPT_RD;
                        default:   n_state = C_SCAN;
                    endcase
                end
            end
            C_ENQ:    n_state = C_PUSH;
            C_RPT_RD: n_state = C_RPT_WR;
            C_RPT_WR: n_state = C_PUSH;
            C_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = C_PUSH;
                end
            end
            C_PUSH: begin
                if (i_stat.out_free) begin
                    n_state = C_IDLE;
                end
            end
            default: n_state = C_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd         = '0;
        case (r_state)
            C_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            C_ENQ:    o_cmd.enq  = 1'b1;
            C_RPT_WR: o_cmd.rpt  = 1'b1;
            C_SCAN:   o_cmd.scan = 1'b1;
            C_PUSH:   o_cmd.push = i_stat.out_free;
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

/* design/rbs_dpath.sv */
// ----------------------------------------------------------------------------
// rbs_dpath: slot table and evaluation logic of the retry backoff scheduler
// State flops, attempt record and queue time memories, scan pipeline,
// result and output registers, configuration registers.
// ----------------------------------------------------------------------------
module rbs_dpath #(
    parameter int SLOTS = rbs_pkg::SLOTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rbs_pkg::t_in_word                 i_word,
    input  rbs_pkg::t_cmd                     i_cmd,
    input  logic                              i_out_ready,
    input  logic                              i_cfg_we,
    input  logic [rbs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rbs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output rbs_pkg::t_stat                    o_stat,
    output logic                              o_out_valid,
    output rbs_pkg::t_out_word                o_out_word
);
    import rbs_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SW-1:0] LAST_ADDR = SW'(SLOTS - 1);

    // configuration
    logic [DELAY_W-1:0] r_max_delay;
    logic [AGE_W-1:0]   r_max_age;

    // captured request
    t_func              r_func;
    logic [SLOT_W-1:0]  r_slot;
    logic [TIME_W-1:0]  r_now;
    logic               r_success;
    logic [CODE_W-1:0]  r_code;

    // table
    t_slot_st           r_state [SLOTS];
    t_meta              r_mem_meta [SLOTS];
    logic [TIME_W-1:0]  r_mem_q [SLOTS];
    t_meta              r_rd_meta;
    logic [TIME_W-1:0]  r_rd_q;

    // scan pipeline
    logic [SW-1:0]      r_addr;
    logic [SW-1:0]      r_ev_addr;
    logic               r_ev_vld;
    logic               r_issue_done;
    logic [SWEPT_W-1:0] r_cnt;

    // result path
    t_out_word          r_res;
    t_out_word          r_out;
    logic               r_out_vld;

    t_out_word          res_next;
    t_slot_st           ev_st;
    logic               slot_ok;
    logic               rpt_live;
    logic [COUNT_W-1:0] cnt_inc;
    logic               rpt_ok;
    logic [DELAY_W-1:0] rpt_bo;
    t_slot_st           rpt_state;
    logic [COUNT_W-1:0] rpt_cnt;
    logic [CODE_W-1:0]  rpt_err;
    logic [DELAY_W-1:0] bo_rd;
    logic [TIME_W-1:0]  since_last;
    logic [TIME_W-1:0]  age;
    logic               pick_pend;
    logic               pick_ret;
    logic               pick_hit;
    logic               stale;
    logic               ev_last;
    logic [SWEPT_W-1:0] cnt_next;

    // ---- evaluation --------------------------------------------------------
    always_comb begin
        ev_st    = r_state[r_ev_addr];
        slot_ok  = (32'(r_slot) < SLOTS);
        rpt_live = slot_ok && (ev_st != SLOT_EMPTY);

        // attempt report
        cnt_inc   = (r_rd_meta.cnt == COUNT_MAX) ? r_rd_meta.cnt
                                                 : r_rd_meta.cnt + 8'd1;
        rpt_ok    = retry_ok(cnt_inc, r_code);
        rpt_bo    = rpt_ok ? backoff_calc(cnt_inc, r_max_delay) : '0;
        rpt_state = r_success ? SLOT_SENT : (rpt_ok ? SLOT_RETRYING : SLOT_FAILED);
        rpt_cnt   = r_success ? r_rd_meta.cnt : cnt_inc;
        rpt_err   = r_success ? r_rd_meta.err : r_code;

        // pick next
        bo_rd      = backoff_calc(r_rd_meta.cnt, r_max_delay);
        since_last = r_now - r_rd_meta.last;
        pick_pend  = (ev_st == SLOT_PENDING);
        pick_ret   = (ev_st == SLOT_RETRYING)
                     && retry_ok(r_rd_meta.cnt, r_rd_meta.err)
                     && (r_now >= r_rd_meta.last)
                     && (since_last >= TIME_W'(bo_rd));
        pick_hit   = r_ev_vld && (pick_pend || pick_ret);

        // sweep; backwards time never ages
        age      = r_now - r_rd_q;
        stale    = r_ev_vld
                   && ((ev_st == SLOT_PENDING) || (ev_st == SLOT_RETRYING))
                   && (r_now >= r_rd_q)
                   && (age > TIME_W'(r_max_age));
        cnt_next = (stale && (r_cnt != SWEPT_MAX)) ? r_cnt + 5'd1 : r_cnt;

        ev_last  = (r_ev_addr == LAST_ADDR);
    end

    assign o_stat.scan_done = r_ev_vld && (ev_last || ((r_func == F_PICK) && pick_hit));
    assign o_stat.out_free  = !r_out_vld || i_out_ready;

    // ---- result word -------------------------------------------------------
    always_comb begin
        res_next          = '0;
        res_next.status   = ST_DONE;
        res_next.slot_out = r_slot;
        case (r_func)
            F_ENQUEUE: begin
                if (slot_ok) begin
                    res_next.slot_state_out = SLOT_PENDING;
                end
            end
            F_REPORT: begin
                if (rpt_live) begin
                    res_next.slot_state_out = rpt_state;
                    res_next.will_retry     = !r_success && rpt_ok;
                    res_next.backoff_ms     = r_success ? '0 : rpt_bo;
                    res_next.retries        = rpt_cnt;
                end
            end
            F_PICK: begin
                res_next.slot_out = '0;
                if (pick_hit) begin
                    res_next.status         = ST_CHOSEN;
                    res_next.slot_out       = SLOT_W'(r_ev_addr);
                    res_next.slot_state_out = ev_st;
                    res_next.will_retry     = pick_ret;
                    res_next.backoff_ms     = pick_ret ? bo_rd : '0;
                    res_next.retries        = r_rd_meta.cnt;
                end else begin
                    res_next.status = ST_NONE;
                end
            end
            F_SWEEP: begin
                res_next.slot_out    = '0;
                res_next.swept_count = cnt_next;
            end
            default: res_next = '0;
        endcase
    end

    // ---- configuration -----------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_delay <= MAX_DELAY_RST;
            r_max_age   <= MAX_AGE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_DELAY: r_max_delay <= i_cfg_data[DELAY_W-1:0];
                CFG_MAX_AGE:   r_max_age   <= i_cfg_data[AGE_W-1:0];
                default:       r_max_age   <= r_max_age;
            endcase
        end
    end

    // ---- slot states, cleared at reset --------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_state[i] <= SLOT_EMPTY;
            end
        end else if (i_cmd.enq && slot_ok) begin
            r_state[r_ev_addr] <= SLOT_PENDING;
        end else if (i_cmd.rpt && rpt_live) begin
            r_state[r_ev_addr] <= rpt_state;
        end else if (i_cmd.scan && (r_func == F_SWEEP) && stale) begin
            r_state[r_ev_addr] <= SLOT_FAILED;
        end
    end

    // ---- record memories ---------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.enq && slot_ok) begin
            r_mem_meta[r_ev_addr] <= '0;
            r_mem_q[r_ev_addr]    <= r_now;
        end else if (i_cmd.rpt && rpt_live) begin
            r_mem_meta[r_ev_addr] <= '{cnt: rpt_cnt, err: rpt_err, last: r_now};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_meta <= r_mem_meta[r_addr];
        r_rd_q    <= r_mem_q[r_addr];
    end

    // ---- request capture and scan pipeline ---------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev_vld     <= 1'b0;
            r_issue_done <= 1'b0;
        end else if (i_cmd.capture) begin
            r_ev_vld     <= 1'b0;
            r_issue_done <= 1'b0;
        end else if (i_cmd.scan) begin
            r_ev_vld <= !r_issue_done;
            if (!r_issue_done && (r_addr == LAST_ADDR)) begin
                r_issue_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func    <= t_func'(i_word.func);
            r_slot    <= i_word.slot;
            r_now     <= i_word.now_ms;
            r_success <= i_word.success;
            r_code    <= i_word.error_code;
            r_cnt     <= '0;
            r_ev_addr <= SW'(i_word.slot);
            if ((t_func'(i_word.func) == F_PICK) || (t_func'(i_word.func) == F_SWEEP)) begin
                r_addr <= '0;
            end else begin
                r_addr <= SW'(i_word.slot);
            end
        end else if (i_cmd.scan) begin
            if (r_ev_vld) begin
                r_cnt <= cnt_next;
            end
            if (!r_issue_done) begin
                r_ev_addr <= r_addr;
                if (r_addr != LAST_ADDR) begin
                    r_addr <= r_addr + 1'b1;
                end
            end
        end
    end

    // ---- result and output registers ---------------------------------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.enq || i_cmd.rpt || (i_cmd.scan && o_stat.scan_done)) begin
            r_res <= res_next;
        end
        if (i_cmd.push) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

endmodule

/* design/retry_backoff_scheduler.sv */
// ----------------------------------------------------------------------------
// retry_backoff_scheduler: capped exponential backoff retry scheduler
// Slot table of outgoing messages with enqueue, attempt report, pick-next
// and stale sweep operations.
// ----------------------------------------------------------------------------
// One request word is worked at a time and gives exactly one result word.
// Enqueue goes through C_ENQ and C_PUSH, an attempt report through C_RPT_RD,
// C_RPT_WR and C_PUSH, and pick-next and sweep through C_SCAN and C_PUSH: they
// walk the table one slot per cycle through the single read port of the
// slot record memory, pick-next stopping at the first slot it can send.
// The result sits in an output register, so a new request is taken while
// the previous result is still waiting; the block only holds back at the
// end of an item when that register is still full. Slot states clear at
// reset; the attempt records carry no reset and are written by enqueue
// before anything reads them. The user must make configuration writes only
// while no request is in flight (the block does not enforce it): index
// CFG_MAX_DELAY caps the backoff, CFG_MAX_AGE sets the age at which unsent messages are swept to failed.
// ----------------------------------------------------------------------------
module retry_backoff_scheduler #(
    parameter int SLOTS = rbs_pkg::SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    rbs_in_if.sink                         i_in,
    rbs_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [rbs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rbs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rbs_pkg::*;

    t_cmd      cmd;    // sequencer -> datapath
    t_stat     stat;   // datapath -> sequencer
    logic      in_ready;
    logic      out_valid;
    t_out_word out_word;

    rbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_func     (i_in.payload.func),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    rbs_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_word      (i_in.payload),
        .i_cmd       (cmd),
        .i_out_ready (o_out.ready),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_stat      (stat),
        .o_out_valid (out_valid),
        .o_out_word  (out_word)
    );

    assign i_in.ready    = in_ready;
    assign o_out.valid   = out_valid;
    assign o_out.payload = out_word;

    // one word in flight: ready drops right after a word is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("request taken while another is in flight");

    // a chosen slot is always pending or retrying
    a_chosen_sendable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.payload.status == ST_CHOSEN)) |->
        ((o_out.payload.slot_state_out == SLOT_PENDING) ||
         (o_out.payload.slot_state_out == SLOT_RETRYING)))
        else $error("chosen slot not sendable");

    // no backoff without a retry
    a_backoff_needs_retry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.payload.will_retry) |-> (o_out.payload.backoff_ms == '0))
        else $error("backoff reported without retry");

    // sweep count only comes with a plain done word
    a_sweep_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.payload.swept_count != '0)) |->
        ((o_out.payload.status == ST_DONE) && (o_out.payload.slot_out == '0)))
        else $error("sweep count on a non-sweep word");

endmodule
